// ===== design/i2clsr_pkg.sv =====
// package for the i2c light sensor reader core
// item structs, bus phase codes, request kinds, register indices and reset values, lux conversion
// no dependencies
`default_nettype none
package i2clsr_pkg;

  typedef struct packed {
    logic [1:0] kind;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        busy_res;
    logic        done_res;
    logic        status;
    logic [15:0] raw_light;
    logic [19:0] lux_q4;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ST1  = 4'd1,
    PH_ST2  = 4'd2,
    PH_ST3  = 4'd3,
    PH_TXA  = 4'd4,
    PH_TXB  = 4'd5,
    PH_TXC  = 4'd6,
    PH_ACKL = 4'd7,
    PH_ACKH = 4'd8,
    PH_RXA  = 4'd9,
    PH_RXB  = 4'd10,
    PH_RXC  = 4'd11,
    PH_MAL  = 4'd12,
    PH_MAH  = 4'd13,
    PH_SPA  = 4'd14,
    PH_SPB  = 4'd15
  } phase_t;

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_POWER   = 2'd1;
  localparam logic [1:0] KIND_MEASURE = 2'd2;
  localparam logic [1:0] KIND_READ    = 2'd3;

  localparam logic [2:0] REG_DEV_ADDR  = 3'd0;
  localparam logic [2:0] REG_POLL_LIM  = 3'd1;
  localparam logic [2:0] REG_PWR_CMD   = 3'd2;
  localparam logic [2:0] REG_MEAS_CMD  = 3'd3;

  localparam logic [6:0] DEV_ADDR_RST  = 7'd35;
  localparam logic [7:0] POLL_LIM_RST  = 8'd10;
  localparam logic [7:0] PWR_CMD_RST   = 8'd1;
  localparam logic [7:0] MEAS_CMD_RST  = 8'd16;

  localparam logic [3:0]  BITS_PER_BYTE = 4'd8;
  localparam logic [16:0] DIV3_RECIP    = 17'd43691;
  localparam int          DIV3_SHIFT    = 17;

  // raw*40/3 truncated, written as 13*raw + raw/3
  function automatic logic [19:0] lux_of(input logic [15:0] raw);
    logic [32:0] prod;
    logic [15:0] third;
    logic [19:0] thirteen;
    prod     = {17'd0, raw} * {16'd0, DIV3_RECIP};
    third    = 16'(prod >> DIV3_SHIFT);
    thirteen = {raw, 3'd0} + {1'b0, raw, 2'd0} + {4'd0, raw};
    lux_of   = thirteen + {4'd0, third};
  endfunction

endpackage
`default_nettype wire

// ===== design/i2c_light_sensor_reader_core.sv =====
// i2c light sensor reader core, top level
// tick-driven i2c master with output register, uses i2clsr_pkg
//
// usage:
//   in_valid/in_ready carry one bus tick per item: a request kind (plain tick,
//   power on, start measure, read value) and the sampled sda level.
//   out_valid/out_ready carry one result per tick: scl and sda drive levels,
//   busy and done flags, the last status, the raw reading and lux in q16.4.
//   cfg_wr_en/cfg_index/cfg_wdata write the address, poll limit and command
//   bytes; write them only while no transaction is running.
//   the result of a tick is registered and appears in the cycle after it is accepted.
//   throughput: one tick per cycle unless stalled; bus state update and lux
//   multiply sit in one pass between the accept edge and the output register.
//   requests are taken only while idle; a request while busy is ignored.
//   a stalled receiver holds the output register; in_ready falls until
//   the waiting result is taken, so no tick is lost.
//   reset: synchronous, active low; bus idle, registers at their defaults,
//   reading and status cleared, no result pending.
`default_nettype none
module i2c_light_sensor_reader_core
  import i2clsr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_wr_en,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  logic [6:0] dev_addr_r;
  logic [7:0] poll_lim_r, pwr_cmd_r, meas_cmd_r;

  phase_t     phase_r, phase_nxt;
  logic [1:0] ttype_r, ttype_nxt;
  logic [3:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic [7:0] high_r, high_nxt;
  logic [15:0] reading_r, reading_nxt;
  logic       status_r, status_nxt;
  logic [1:0] stage_r, stage_nxt;
  logic       fail_r, fail_nxt;

  logic       out_valid_r;
  out_item_t  out_data_r, out_data_nxt;

  logic       in_accept;
  logic       scl, sdo, busy, done;
  logic [1:0] stage_inc;
  logic [3:0] bit_cnt_inc;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RST;
      poll_lim_r <= POLL_LIM_RST;
      pwr_cmd_r  <= PWR_CMD_RST;
      meas_cmd_r <= MEAS_CMD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DEV_ADDR: dev_addr_r <= cfg_wdata[6:0];
        REG_POLL_LIM: poll_lim_r <= cfg_wdata;
        REG_PWR_CMD:  pwr_cmd_r  <= cfg_wdata;
        REG_MEAS_CMD: meas_cmd_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    ttype_nxt   = ttype_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    poll_nxt    = poll_r;
    high_nxt    = high_r;
    reading_nxt = reading_r;
    status_nxt  = status_r;
    stage_nxt   = stage_r;
    fail_nxt    = fail_r;
    scl         = 1'b1;
    sdo         = 1'b1;
    busy        = 1'b1;
    done        = 1'b0;
    stage_inc   = stage_r + 2'd1;
    bit_cnt_inc = bit_cnt_r + 4'd1;

    unique case (phase_r)
      PH_IDLE: begin
        if (in_data.kind == KIND_TICK) begin
          busy = 1'b0;
        end else begin
          ttype_nxt = in_data.kind;
          stage_nxt = 2'd0;
          fail_nxt  = 1'b0;
          poll_nxt  = 8'd0;
          phase_nxt = PH_ST1;
        end
      end
      PH_ST1: phase_nxt = PH_ST2;
      PH_ST2: begin
        sdo       = 1'b0;
        phase_nxt = PH_ST3;
      end
      PH_ST3: begin
        scl         = 1'b0;
        sdo         = 1'b0;
        shift_nxt   = {dev_addr_r, (ttype_r == KIND_READ)};
        bit_cnt_nxt = 4'd0;
        phase_nxt   = PH_TXA;
      end
      PH_TXA: begin
        scl       = 1'b0;
        sdo       = shift_r[7];
        phase_nxt = PH_TXB;
      end
      PH_TXB: begin
        sdo       = shift_r[7];
        phase_nxt = PH_TXC;
      end
      PH_TXC: begin
        scl         = 1'b0;
        sdo         = shift_r[7];
        shift_nxt   = {shift_r[6:0], 1'b0};
        bit_cnt_nxt = bit_cnt_inc;
        if (bit_cnt_inc >= BITS_PER_BYTE) begin
          phase_nxt = PH_ACKL;
          poll_nxt  = 8'd0;
        end else begin
          phase_nxt = PH_TXA;
        end
      end
      PH_ACKL: begin
        scl       = 1'b0;
        phase_nxt = PH_ACKH;
      end
      PH_ACKH: begin
        if (!in_data.sda_sample) begin
          stage_nxt = stage_inc;
          if (ttype_r == KIND_READ) begin
            shift_nxt   = 8'd0;
            bit_cnt_nxt = 4'd0;
            phase_nxt   = PH_RXA;
          end else if (stage_inc == 2'd1) begin
            shift_nxt   = (ttype_r == KIND_POWER) ? pwr_cmd_r : meas_cmd_r;
            bit_cnt_nxt = 4'd0;
            phase_nxt   = PH_TXA;
          end else begin
            phase_nxt = PH_SPA;
          end
        end else if (poll_r < poll_lim_r) begin
          poll_nxt = poll_r + 8'd1;
        end else begin
          fail_nxt  = 1'b1;
          phase_nxt = PH_SPA;
        end
      end
      PH_RXA: begin
        scl       = 1'b0;
        phase_nxt = PH_RXB;
      end
      PH_RXB: begin
        shift_nxt = {shift_r[6:0], in_data.sda_sample};
        phase_nxt = PH_RXC;
      end
      PH_RXC: begin
        bit_cnt_nxt = bit_cnt_inc;
        if (bit_cnt_inc >= BITS_PER_BYTE) begin
          if (stage_r == 2'd1) high_nxt = shift_r;
          phase_nxt = PH_MAL;
        end else begin
          phase_nxt = PH_RXA;
        end
      end
      PH_MAL: begin
        scl       = 1'b0;
        sdo       = 1'b0;
        phase_nxt = PH_MAH;
      end
      PH_MAH: begin
        sdo = (stage_r == 2'd2);
        if (stage_r == 2'd1) begin
          stage_nxt   = 2'd2;
          shift_nxt   = 8'd0;
          bit_cnt_nxt = 4'd0;
          phase_nxt   = PH_RXA;
        end else begin
          phase_nxt = PH_SPA;
        end
      end
      PH_SPA: begin
        sdo       = 1'b0;
        phase_nxt = PH_SPB;
      end
      PH_SPB: begin
        done       = 1'b1;
        status_nxt = fail_r;
        if (!fail_r && ttype_r == KIND_READ) reading_nxt = {high_r, shift_r};
        phase_nxt  = PH_IDLE;
      end
      default: begin
        busy      = 1'b0;
        phase_nxt = PH_IDLE;
      end
    endcase

    out_data_nxt.scl_level = scl;
    out_data_nxt.sda_level = sdo;
    out_data_nxt.busy_res  = busy;
    out_data_nxt.done_res  = done;
    out_data_nxt.status    = status_nxt;
    out_data_nxt.raw_light = reading_nxt;
    out_data_nxt.lux_q4    = lux_of(reading_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      ttype_r   <= 2'd0;
      bit_cnt_r <= 4'd0;
      shift_r   <= 8'd0;
      poll_r    <= 8'd0;
      high_r    <= 8'd0;
      reading_r <= 16'd0;
      status_r  <= 1'b0;
      stage_r   <= 2'd0;
      fail_r    <= 1'b0;
    end else if (in_accept) begin
      phase_r   <= phase_nxt;
      ttype_r   <= ttype_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      poll_r    <= poll_nxt;
      high_r    <= high_nxt;
      reading_r <= reading_nxt;
      status_r  <= status_nxt;
      stage_r   <= stage_nxt;
      fail_r    <= fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) out_data_r <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= BITS_PER_BYTE)
    else $error("bit counter beyond one byte");

  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && phase_r == PH_IDLE && in_data.kind == KIND_TICK)
      |=> (out_valid_r && !out_data_r.busy_res && phase_r == PH_IDLE))
    else $error("plain tick while idle left the bus busy");

  a_stop_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && phase_r == PH_SPB)
      |=> (out_data_r.done_res && out_data_r.busy_res && phase_r == PH_IDLE))
    else $error("stop did not finish the transaction");
`endif

endmodule
`default_nettype wire
